@@ hdl/lcc_pkg.sv @@
// Shared types, constants and a function for the Luhn card number classifier.
`default_nettype none

package lcc_pkg;

	localparam int N_BITS         = 54;
	localparam int N_DIGITS       = 17;
	localparam int BCD_W          = 4 * N_DIGITS;
	localparam int MIN_DIGITS     = 13;
	localparam int MAX_DIGITS_DEF = 16;
	localparam int IN_TDATA_W     = 56;
	localparam int OUT_TDATA_W    = 8;

	typedef enum logic [1:0] {
		CLASS_INVALID = 2'd0,
		CLASS_AMEX    = 2'd1,
		CLASS_VISA    = 2'd2,
		CLASS_MASTER  = 2'd3
	} class_t;

	// binary to BCD conversion state
	typedef struct packed {
		logic [BCD_W-1:0]  bcd;
		logic [N_BITS-1:0] bin;
	} dab_t;

	// digit scan state
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [3:0]       sum;
		logic [4:0]       count;
		logic [3:0]       cur;
		logic [3:0]       below;
	} luhn_t;

	function automatic class_t classify_lead(input logic [3:0] cur, input logic [3:0] below);
		logic [6:0] lead;
		class_t     cls;
		lead = 7'({3'd0, cur} * 7'd10) + {3'd0, below};
		cls  = CLASS_INVALID;
		if (lead == 7'd34 || lead == 7'd37)
			cls = CLASS_AMEX;
		else if (lead > 7'd39 && lead < 7'd50)
			cls = CLASS_VISA;
		else if (lead > 7'd50 && lead < 7'd56)
			cls = CLASS_MASTER;
		return cls;
	endfunction

endpackage

`default_nettype wire

@@ hdl/lcc_dabble_cell.sv @@
// One shift-and-add-3 step of the binary to BCD conversion chain.
`default_nettype none

module lcc_dabble_cell
	import lcc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire dab_t in_data,
	output logic      out_valid,
	output dab_t      out_data
);

	logic valid_q;
	dab_t data_q;
	dab_t nxt;
	logic [BCD_W-1:0] adj;

	always_comb begin
		for (int j = 0; j < N_DIGITS; j++) begin
			if (in_data.bcd[4*j +: 4] >= 4'd5)
				adj[4*j +: 4] = in_data.bcd[4*j +: 4] + 4'd3;
			else
				adj[4*j +: 4] = in_data.bcd[4*j +: 4];
		end
		nxt.bcd = {adj[BCD_W-2:0], in_data.bin[N_BITS-1]};
		nxt.bin = {in_data.bin[N_BITS-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

@@ hdl/lcc_luhn_cell.sv @@
// One digit of the Luhn scan: weighted sum mod ten, digit count, leading pair.
`default_nettype none

module lcc_luhn_cell
	import lcc_pkg::*;
#(
	parameter int IDX = 0
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire luhn_t in_data,
	output logic       out_valid,
	output luhn_t      out_data
);

	localparam int BIDX = (IDX > 0) ? IDX - 1 : 0;

	logic       valid_q;
	luhn_t      data_q;
	luhn_t      nxt;
	logic [3:0] d;
	logic [4:0] dbl;
	logic [3:0] t;
	logic [4:0] s;

	always_comb begin
		d   = in_data.bcd[4*IDX +: 4];
		dbl = {d, 1'b0};
		if (IDX % 2 == 1)
			t = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
		else
			t = d;
		s = {1'b0, in_data.sum} + {1'b0, t};
		if (s >= 5'd10)
			s = s - 5'd10;
		nxt     = in_data;
		nxt.sum = s[3:0];
		if (d != 4'd0) begin
			nxt.count = 5'(IDX + 1);
			nxt.cur   = d;
			nxt.below = (IDX > 0) ? in_data.bcd[4*BIDX +: 4] : 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

@@ hdl/luhn_card_number_classifier_core.sv @@
// Top level of the Luhn card number classifier: cell chains, output stage, flow control.
//
// Usage: one card number per beat on the slave stream (s_tdata[53:0]), one result
// per beat on the master stream (m_tdata: class, Luhn flag, digit count).
// Datapath: 54 shift-and-add-3 cells turn the number into 17 BCD digits, then
// 17 scan cells fold in one digit each, then a single output register classifies.
// Throughput: one beat per cycle, sustained while m_tready stays high.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// collapse: while m_tready is low the chain keeps accepting until all 72 stages
// are full, and only then s_tready drops.
// Reset clears every stage valid flag; nothing is emitted until a beat arrives.
// Results appear in input order, one for each accepted number.
`default_nettype none

module luhn_card_number_classifier_core
	import lcc_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [53:0] card_number, [55:54] zero
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata    // [1:0] card_class, [2] luhn_ok, [7:3] digit_count
);

	localparam int NST = N_BITS + N_DIGITS + 1;

	logic [NST-1:0] stv;
	logic [NST-1:0] stall;
	logic [NST-1:0] en;

	dab_t  dab_d [N_BITS+1];
	logic  dab_v [N_BITS+1];
	luhn_t lu_d  [N_DIGITS+1];
	logic  lu_v  [N_DIGITS+1];

	logic   out_valid_q;
	class_t out_class_q;
	logic   out_ok_q;
	logic [4:0] out_count_q;

	class_t cls;
	logic   ok;

	// stall ripples back only through occupied stages
	assign stall[NST-1] = stv[NST-1] & ~m_tready;
	genvar gi;
	generate
		for (gi = 0; gi < NST - 1; gi++) begin : g_stall
			assign stall[gi] = stv[gi] & stall[gi+1];
		end
	endgenerate
	assign en       = ~stall;
	assign s_tready = en[0];

	assign dab_v[0]       = s_tvalid;
	assign dab_d[0].bin   = s_tdata[N_BITS-1:0];
	assign dab_d[0].bcd   = '0;

	generate
		for (gi = 0; gi < N_BITS; gi++) begin : g_dab
			lcc_dabble_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en[gi]),
				.in_valid (dab_v[gi]),
				.in_data  (dab_d[gi]),
				.out_valid(dab_v[gi+1]),
				.out_data (dab_d[gi+1])
			);
			assign stv[gi] = dab_v[gi+1];
		end
	endgenerate

	assign lu_v[0]       = dab_v[N_BITS];
	assign lu_d[0].bcd   = dab_d[N_BITS].bcd;
	assign lu_d[0].sum   = 4'd0;
	assign lu_d[0].count = 5'd0;
	assign lu_d[0].cur   = 4'd0;
	assign lu_d[0].below = 4'd0;

	generate
		for (gi = 0; gi < N_DIGITS; gi++) begin : g_luhn
			lcc_luhn_cell #(.IDX(gi)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en[N_BITS+gi]),
				.in_valid (lu_v[gi]),
				.in_data  (lu_d[gi]),
				.out_valid(lu_v[gi+1]),
				.out_data (lu_d[gi+1])
			);
			assign stv[N_BITS+gi] = lu_v[gi+1];
		end
	endgenerate

	always_comb begin
		ok  = (lu_d[N_DIGITS].sum == 4'd0);
		cls = CLASS_INVALID;
		if (ok && lu_d[N_DIGITS].count >= 5'(MIN_DIGITS) &&
			lu_d[N_DIGITS].count <= 5'(MAX_DIGITS))
			cls = classify_lead(lu_d[N_DIGITS].cur, lu_d[N_DIGITS].below);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en[NST-1])
			out_valid_q <= lu_v[N_DIGITS];
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			out_class_q <= cls;
			out_ok_q    <= ok;
			out_count_q <= lu_d[N_DIGITS].count;
		end
	end

	assign stv[NST-1] = out_valid_q;
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {out_count_q, out_ok_q, out_class_q};

	// a classified card always passed the check
	a_class_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != CLASS_INVALID |-> m_tdata[2])
		else $error("classified result without Luhn pass");

	// a classified card has an accepted length
	a_class_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != CLASS_INVALID |->
		m_tdata[7:3] >= 5'(MIN_DIGITS) && m_tdata[7:3] <= 5'(MAX_DIGITS))
		else $error("classified result with bad digit count");

	// 54 bits never make more than 17 digits
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:3] <= 5'(N_DIGITS))
		else $error("digit count out of range");

	// back-pressure reaches the input only when the output is blocked
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output free");

endmodule

`default_nettype wire
